// File: rtl/kpd_pkg.sv
// ----------------------------------------------------------------------------
// kpd_pkg
// Shared types, key table and constants of the keypad autorepeat block.
// ----------------------------------------------------------------------------
package kpd_pkg;

	localparam int TABLE_KEYS = 13;
	localparam int KEY_W      = 4;
	localparam int SCAN_A_W   = 4;
	localparam int SCAN_B_W   = 17;
	localparam int SCAN_C_W   = 16;
	localparam int TICK_W     = 32;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_W-1:0] INITIAL_DELAY_RST   = 16'd500;
	localparam logic [CFG_W-1:0] REPEAT_INTERVAL_RST = 16'd175;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INITIAL_DELAY   = 1'b0,
		REG_REPEAT_INTERVAL = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		GRP_A = 2'd0,
		GRP_B = 2'd1,
		GRP_C = 2'd2
	} grp_t;

	typedef struct packed {
		grp_t                grp;
		logic [SCAN_B_W-1:0] mask;
	} key_entry_t;

	localparam key_entry_t KEY_TABLE [TABLE_KEYS] = '{
		'{GRP_A, 17'h00008}, '{GRP_A, 17'h00004}, '{GRP_A, 17'h00001}, '{GRP_A, 17'h00002},
		'{GRP_B, 17'h04000}, '{GRP_B, 17'h00800}, '{GRP_B, 17'h10000},
		'{GRP_C, 17'h01001}, '{GRP_C, 17'h01000}, '{GRP_C, 17'h00001},
		'{GRP_C, 17'h04000}, '{GRP_C, 17'h02000}, '{GRP_C, 17'h00040}
	};

	typedef struct packed {
		logic [KEY_W-1:0] clicked;
		logic [KEY_W-1:0] pressed;
	} key_codes_t;

	// active low: a key is down when all of its bits read zero
	function automatic logic key_pressed(
		input logic [SCAN_A_W-1:0] a,
		input logic [SCAN_B_W-1:0] b,
		input logic [SCAN_C_W-1:0] c,
		input key_entry_t          e
	);
		logic [SCAN_B_W-1:0] word;
		unique case (e.grp)
			GRP_A:   word = {{(SCAN_B_W-SCAN_A_W){1'b0}}, a};
			GRP_B:   word = b;
			GRP_C:   word = {{(SCAN_B_W-SCAN_C_W){1'b0}}, c};
			default: word = '1;
		endcase
		return (word & e.mask) == '0;
	endfunction

endpackage

// File: rtl/kpd_scan_decode.sv
// ----------------------------------------------------------------------------
// kpd_scan_decode
// Maps current and prior scans through the key table; finds first clicked
// and first pressed key.
// ----------------------------------------------------------------------------
module kpd_scan_decode import kpd_pkg::*; #(
	parameter int KEY_LIMIT = 13
) (
	input  logic [SCAN_A_W-1:0]  cur_a,
	input  logic [SCAN_B_W-1:0]  cur_b,
	input  logic [SCAN_C_W-1:0]  cur_c,
	input  logic [SCAN_A_W-1:0]  prv_a,
	input  logic [SCAN_B_W-1:0]  prv_b,
	input  logic [SCAN_C_W-1:0]  prv_c,
	output logic [KEY_LIMIT-1:0] down_now,
	output key_codes_t           codes
);

	logic [KEY_LIMIT-1:0] down_prv;

	always_comb begin
		codes = '0;
		for (int i = KEY_LIMIT - 1; i >= 0; i--) begin
			down_now[i] = key_pressed(cur_a, cur_b, cur_c, KEY_TABLE[i]);
			down_prv[i] = key_pressed(prv_a, prv_b, prv_c, KEY_TABLE[i]);
			if (down_now[i]) begin
				codes.pressed = KEY_W'(i + 1);
			end
			if (down_now[i] && !down_prv[i]) begin
				codes.clicked = KEY_W'(i + 1);
			end
		end
	end

endmodule

// File: rtl/kpd_autorepeat.sv
// ----------------------------------------------------------------------------
// kpd_autorepeat
// Tracks the clicked key, passes a new click through as repeat key, and
// issues repeats after the initial delay and then every repeat interval while it stays held.
// ----------------------------------------------------------------------------
module kpd_autorepeat import kpd_pkg::*; #(
	parameter int KEY_LIMIT = 13
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic [KEY_W-1:0]     clicked,
	input  logic [KEY_LIMIT-1:0] down_now,
	input  logic [TICK_W-1:0]    tick,
	input  logic [CFG_W-1:0]     initial_delay,
	input  logic [CFG_W-1:0]     repeat_interval,
	output logic [KEY_W-1:0]     repeat_key
);

	logic [KEY_W-1:0]  tracked_q;
	logic [TICK_W-1:0] last_q;
	logic              once_q;

	logic              held;
	logic              fire;
	logic [TICK_W-1:0] elapsed;
	logic [CFG_W-1:0]  wait_ticks;

	always_comb begin
		held = 1'b0;
		for (int i = 0; i < KEY_LIMIT; i++) begin
			if (tracked_q == KEY_W'(i + 1) && down_now[i]) begin
				held = 1'b1;
			end
		end
		elapsed    = tick - last_q;
		wait_ticks = once_q ? repeat_interval : initial_delay;
		fire       = held && (elapsed > {{(TICK_W-CFG_W){1'b0}}, wait_ticks});
		if (clicked != '0) begin
			repeat_key = clicked;
		end else if (fire) begin
			repeat_key = tracked_q;
		end else begin
			repeat_key = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracked_q <= '0;
			last_q    <= '0;
			once_q    <= 1'b0;
		end else if (advance) begin
			if (clicked != '0) begin
				tracked_q <= clicked;
				last_q    <= tick;
				once_q    <= 1'b0;
			end else if (held) begin
				if (fire) begin
					last_q <= tick;
					once_q <= 1'b1;
				end
			end else begin
				tracked_q <= '0;
			end
		end
	end

endmodule

// File: rtl/keypad_edge_autorepeat.sv
// ----------------------------------------------------------------------------
// keypad_edge_autorepeat
// Keypad click/press detector with key autorepeat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one active-low scan per
//   transaction: scan_group_a/b/c and tick_time. Output channel
//   (out_valid/out_ready) returns one result per scan: clicked_key,
//   pressed_key and repeat_key, codes 1..13 in table order, 0 for none.
//   Config channel (cfg_valid/cfg_ready, always ready) writes
//   initial_delay (index 0) or repeat_interval (index 1) from the 16-bit
//   cfg_data; write only while the block is idle.
//   Timing: a scan is taken into the input register, then its result into
//   the result register. Throughput: one scan per cycle while out_ready is
//   high; key decode, tick subtraction and compare sit in a single stage.
//   Reset clears the prior scan to zero (all keys read as pressed, so nothing
//   clicks on the first scan), drops the tracked key and loads the delay
//   defaults 500 and 175.
//   When out_ready is low the result holds; one more scan is still taken
//   into the input register, then in_ready falls until the result leaves.
// ----------------------------------------------------------------------------
module keypad_edge_autorepeat import kpd_pkg::*; #(
	parameter int NUM_KEYS = 13
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [SCAN_A_W-1:0]  scan_group_a,
	input  logic [SCAN_B_W-1:0]  scan_group_b,
	input  logic [SCAN_C_W-1:0]  scan_group_c,
	input  logic [TICK_W-1:0]    tick_time,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [KEY_W-1:0]     clicked_key,
	output logic [KEY_W-1:0]     pressed_key,
	output logic [KEY_W-1:0]     repeat_key
);

	localparam int KEY_LIMIT = (NUM_KEYS < TABLE_KEYS) ? NUM_KEYS : TABLE_KEYS;

	logic [CFG_W-1:0] initial_delay_q;
	logic [CFG_W-1:0] repeat_interval_q;

	logic                valid_s1;
	logic [SCAN_A_W-1:0] scan_a_s1;
	logic [SCAN_B_W-1:0] scan_b_s1;
	logic [SCAN_C_W-1:0] scan_c_s1;
	logic [TICK_W-1:0]   tick_s1;

	logic [SCAN_A_W-1:0] cur_a_q;
	logic [SCAN_B_W-1:0] cur_b_q;
	logic [SCAN_C_W-1:0] cur_c_q;

	logic                 out_valid_q;
	logic                 advance;
	logic [KEY_LIMIT-1:0] down_now;
	key_codes_t           codes;
	logic [KEY_W-1:0]     rep_code;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_delay_q   <= INITIAL_DELAY_RST;
			repeat_interval_q <= REPEAT_INTERVAL_RST;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_INITIAL_DELAY:   initial_delay_q   <= cfg_data;
				REG_REPEAT_INTERVAL: repeat_interval_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			scan_a_s1 <= scan_group_a;
			scan_b_s1 <= scan_group_b;
			scan_c_s1 <= scan_group_c;
			tick_s1   <= tick_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_a_q <= '0;
			cur_b_q <= '0;
			cur_c_q <= '0;
		end else if (advance) begin
			cur_a_q <= scan_a_s1;
			cur_b_q <= scan_b_s1;
			cur_c_q <= scan_c_s1;
		end
	end

	kpd_scan_decode #(
		.KEY_LIMIT (KEY_LIMIT)
	) u_decode (
		.cur_a    (scan_a_s1),
		.cur_b    (scan_b_s1),
		.cur_c    (scan_c_s1),
		.prv_a    (cur_a_q),
		.prv_b    (cur_b_q),
		.prv_c    (cur_c_q),
		.down_now (down_now),
		.codes    (codes)
	);

	kpd_autorepeat #(
		.KEY_LIMIT (KEY_LIMIT)
	) u_repeat (
		.clk             (clk),
		.arst_n          (arst_n),
		.advance         (advance),
		.clicked         (codes.clicked),
		.down_now        (down_now),
		.tick            (tick_s1),
		.initial_delay   (initial_delay_q),
		.repeat_interval (repeat_interval_q),
		.repeat_key      (rep_code)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			clicked_key <= codes.clicked;
			pressed_key <= codes.pressed;
			repeat_key  <= rep_code;
		end
	end

	a_click_repeats: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clicked_key != '0 |-> repeat_key == clicked_key)
		else $error("click not reported as repeat key");

	a_click_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clicked_key != '0 |-> pressed_key != '0 && pressed_key <= clicked_key)
		else $error("clicked key not covered by pressed key");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

endmodule
